// File: sv/akvs_pkg.sv
package akvs_pkg;

  // default tick period in ms
  localparam int unsigned MS_PER_TICK_DEF = 10;

  // config port
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] REG_INTENSITY    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DOUBLE_MODE  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SUPPORT_EN   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CLOCKWISE    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_REPEAT_COUNT = 3'd4;

  // intensity codes
  localparam logic [1:0] INTENSITY_LOW  = 2'd1;
  localparam logic [1:0] INTENSITY_HIGH = 2'd2;

  // valve vector bit positions
  localparam int unsigned NUM_VALVES = 5;
  localparam int unsigned V_TOP      = 0;
  localparam int unsigned V_RIGHT    = 1;
  localparam int unsigned V_LEFT     = 2;
  localparam int unsigned V_SUP      = 3;
  localparam int unsigned V_REL      = 4;

  typedef logic [NUM_VALVES-1:0] valve_t;

  typedef enum logic [1:0] {
    PH_INFLATE = 2'd0,
    PH_CYCLIC  = 2'd1,
    PH_DEFLATE = 2'd2
  } phase_e;

  // inflate timings in ms
  localparam int unsigned T_DBL_LO_TOT_MS   = 6000;
  localparam int unsigned T_DBL_LO_SUP_MS   = 2000;
  localparam int unsigned T_DBL_LO_NOSUP_MS = 3500;
  localparam int unsigned T_DBL_HI_TOT_MS   = 7000;
  localparam int unsigned T_DBL_HI_SUP_MS   = 2500;
  localparam int unsigned T_DBL_HI_NOSUP_MS = 4000;
  localparam int unsigned T_SGL_LO_TOT_MS   = 3500;
  localparam int unsigned T_SGL_LO_SUP_MS   = 1500;
  localparam int unsigned T_SGL_LO_NOSUP_MS = 2000;
  localparam int unsigned T_SGL_HI_TOT_MS   = 5000;
  localparam int unsigned T_SGL_HI_SUP_MS   = 2000;
  localparam int unsigned T_SGL_HI_NOSUP_MS = 2500;
  localparam int unsigned T_INFLATE_MAX_MS  = 7000;

  // knead segment ends in ms
  localparam int unsigned T_LO_E1_MS = 700;
  localparam int unsigned T_LO_E2_MS = 1400;
  localparam int unsigned T_LO_E3_MS = 2100;
  localparam int unsigned T_HI_E1_MS = 500;
  localparam int unsigned T_HI_E2_MS = 1000;
  localparam int unsigned T_HI_E3_MS = 1500;
  localparam int unsigned T_CYCLE_MAX_MS = 2100;

endpackage

// File: sv/airbag_knead_valve_sequencer.sv
// Airbag knead valve sequencer.
// Input stream: one word per timer tick, s_axis_tdata[0] = tick. A word with
// tick low, intensity idle or repeat_count zero leaves the sequence where it is.
// Output stream: one word per input word with the five valve commands and the
// phase reached after that tick.
// Configuration: cfg_we_i writes cfg_data_i into register cfg_idx_i
// (0 intensity, 1 double_mode, 2 support_enabled, 3 clockwise_dir,
// 4 repeat_count); only write while no word is in flight.
// The result word appears in the cycle after its input word is taken.
// Throughput: one word per cycle while the receiver takes results; the sequence
// state and the single output register are updated in the accept cycle, so the
// tick counters and phase logic are computed combinationally.
// The input side stays ready while the output register is empty or being
// drained in the same cycle; a stalled receiver holds the result and blocks
// new input until it takes it.
// Reset: phase inflate, counters zero, all valves off, no output word,
// clockwise_dir set and the other registers cleared.
module airbag_knead_valve_sequencer #(
  parameter int unsigned MS_PER_TICK = akvs_pkg::MS_PER_TICK_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [akvs_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [akvs_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [7:0]                      s_axis_tdata,  // tick
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // top, right, left, support, support_release, phase_now[1:0], zero pad
  output logic [7:0]                      m_axis_tdata
);

  localparam int unsigned TInfMax = akvs_pkg::T_INFLATE_MAX_MS / MS_PER_TICK;
  localparam int unsigned InfW    = (TInfMax < 1) ? 1 : $clog2(TInfMax + 1);
  localparam int unsigned TCycMax = akvs_pkg::T_CYCLE_MAX_MS / MS_PER_TICK;
  localparam int unsigned CycW    = (TCycMax < 1) ? 1 : $clog2(TCycMax + 1);

  localparam logic [InfW-1:0] TDblLoTot = InfW'(akvs_pkg::T_DBL_LO_TOT_MS / MS_PER_TICK);
  localparam logic [InfW-1:0] TDblLoSup = InfW'(akvs_pkg::T_DBL_LO_SUP_MS / MS_PER_TICK);
  localparam logic [InfW-1:0] TDblLoNo  = InfW'(akvs_pkg::T_DBL_LO_NOSUP_MS / MS_PER_TICK);
  localparam logic [InfW-1:0] TDblHiTot = InfW'(akvs_pkg::T_DBL_HI_TOT_MS / MS_PER_TICK);
  localparam logic [InfW-1:0] TDblHiSup = InfW'(akvs_pkg::T_DBL_HI_SUP_MS / MS_PER_TICK);
  localparam logic [InfW-1:0] TDblHiNo  = InfW'(akvs_pkg::T_DBL_HI_NOSUP_MS / MS_PER_TICK);
  localparam logic [InfW-1:0] TSglLoTot = InfW'(akvs_pkg::T_SGL_LO_TOT_MS / MS_PER_TICK);
  localparam logic [InfW-1:0] TSglLoSup = InfW'(akvs_pkg::T_SGL_LO_SUP_MS / MS_PER_TICK);
  localparam logic [InfW-1:0] TSglLoNo  = InfW'(akvs_pkg::T_SGL_LO_NOSUP_MS / MS_PER_TICK);
  localparam logic [InfW-1:0] TSglHiTot = InfW'(akvs_pkg::T_SGL_HI_TOT_MS / MS_PER_TICK);
  localparam logic [InfW-1:0] TSglHiSup = InfW'(akvs_pkg::T_SGL_HI_SUP_MS / MS_PER_TICK);
  localparam logic [InfW-1:0] TSglHiNo  = InfW'(akvs_pkg::T_SGL_HI_NOSUP_MS / MS_PER_TICK);

  localparam logic [CycW-1:0] TLoE1 = CycW'(akvs_pkg::T_LO_E1_MS / MS_PER_TICK);
  localparam logic [CycW-1:0] TLoE2 = CycW'(akvs_pkg::T_LO_E2_MS / MS_PER_TICK);
  localparam logic [CycW-1:0] TLoE3 = CycW'(akvs_pkg::T_LO_E3_MS / MS_PER_TICK);
  localparam logic [CycW-1:0] THiE1 = CycW'(akvs_pkg::T_HI_E1_MS / MS_PER_TICK);
  localparam logic [CycW-1:0] THiE2 = CycW'(akvs_pkg::T_HI_E2_MS / MS_PER_TICK);
  localparam logic [CycW-1:0] THiE3 = CycW'(akvs_pkg::T_HI_E3_MS / MS_PER_TICK);

  // config registers
  logic [1:0] intensity_q;
  logic       double_mode_q;
  logic       support_en_q;
  logic       clockwise_q;
  logic [7:0] repeat_count_q;

  // sequence state
  akvs_pkg::phase_e phase_q, phase_d;
  logic [InfW-1:0]  infl_ticks_q, infl_ticks_d;
  logic [CycW-1:0]  cyc_ticks_q, cyc_ticks_d;
  logic [7:0]       cycles_done_q, cycles_done_d;
  akvs_pkg::valve_t valve_q, valve_d;

  // output register
  logic       out_vld_q;
  logic [7:0] out_data_q;

  logic            s_acc;
  logic            run;
  logic            high;
  logic [InfW-1:0] total;
  logic [InfW-1:0] first;
  logic [CycW-1:0] e1, e2, e3;
  akvs_pkg::valve_t main_keep;

  assign s_axis_tready = !out_vld_q || m_axis_tready;
  assign s_acc         = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      intensity_q    <= '0;
      double_mode_q  <= 1'b0;
      support_en_q   <= 1'b0;
      clockwise_q    <= 1'b1;
      repeat_count_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        akvs_pkg::REG_INTENSITY:    intensity_q    <= cfg_data_i[1:0];
        akvs_pkg::REG_DOUBLE_MODE:  double_mode_q  <= cfg_data_i[0];
        akvs_pkg::REG_SUPPORT_EN:   support_en_q   <= cfg_data_i[0];
        akvs_pkg::REG_CLOCKWISE:    clockwise_q    <= cfg_data_i[0];
        akvs_pkg::REG_REPEAT_COUNT: repeat_count_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign run  = s_axis_tdata[0] && (intensity_q == akvs_pkg::INTENSITY_LOW ||
                intensity_q == akvs_pkg::INTENSITY_HIGH) && (repeat_count_q != 8'd0);
  assign high = (intensity_q == akvs_pkg::INTENSITY_HIGH);

  // timing selection
  always_comb begin
    unique case ({support_en_q, double_mode_q, high})
      3'b100:  begin total = TSglLoTot; first = TSglLoSup; end
      3'b101:  begin total = TSglHiTot; first = TSglHiSup; end
      3'b110:  begin total = TDblLoTot; first = TDblLoSup; end
      3'b111:  begin total = TDblHiTot; first = TDblHiSup; end
      3'b000:  begin total = TSglLoNo;  first = '0; end
      3'b001:  begin total = TSglHiNo;  first = '0; end
      3'b010:  begin total = TDblLoNo;  first = '0; end
      default: begin total = TDblHiNo;  first = '0; end
    endcase
    e1 = high ? THiE1 : TLoE1;
    e2 = high ? THiE2 : TLoE2;
    e3 = high ? THiE3 : TLoE3;
  end

  always_comb begin
    phase_d       = phase_q;
    infl_ticks_d  = infl_ticks_q;
    cyc_ticks_d   = cyc_ticks_q;
    cycles_done_d = cycles_done_q;
    valve_d       = valve_q;
    main_keep     = valve_q;
    main_keep[akvs_pkg::V_SUP] = 1'b0;
    main_keep[akvs_pkg::V_REL] = 1'b0;
    if (run) begin
      unique case (phase_q)
        akvs_pkg::PH_INFLATE: begin
          if (infl_ticks_q >= total) begin
            infl_ticks_d = '0;
            phase_d      = akvs_pkg::PH_CYCLIC;
          end else begin
            if (support_en_q && infl_ticks_q < first) begin
              valve_d[akvs_pkg::V_SUP] = 1'b1;
              valve_d[akvs_pkg::V_REL] = 1'b0;
            end else begin
              if (support_en_q) begin
                valve_d[akvs_pkg::V_SUP] = 1'b0;
                valve_d[akvs_pkg::V_REL] = 1'b0;
              end
              valve_d[akvs_pkg::V_TOP]   = 1'b1;
              valve_d[akvs_pkg::V_RIGHT] = 1'b1;
              valve_d[akvs_pkg::V_LEFT]  = 1'b1;
            end
            infl_ticks_d = infl_ticks_q + 1'b1;
          end
        end
        akvs_pkg::PH_CYCLIC: begin
          if (cycles_done_q >= repeat_count_q) begin
            cycles_done_d = '0;
            cyc_ticks_d   = '0;
            phase_d       = akvs_pkg::PH_DEFLATE;
          end else begin
            valve_d = main_keep;
            if (cyc_ticks_q < e3) begin
              valve_d[akvs_pkg::V_TOP]   = 1'b1;
              valve_d[akvs_pkg::V_RIGHT] = 1'b1;
              valve_d[akvs_pkg::V_LEFT]  = 1'b1;
              priority if (cyc_ticks_q < e1) begin
                valve_d[akvs_pkg::V_TOP] = 1'b0;
              end else if (cyc_ticks_q < e2) begin
                if (clockwise_q) valve_d[akvs_pkg::V_RIGHT] = 1'b0;
                else             valve_d[akvs_pkg::V_LEFT]  = 1'b0;
              end else begin
                if (clockwise_q) valve_d[akvs_pkg::V_LEFT]  = 1'b0;
                else             valve_d[akvs_pkg::V_RIGHT] = 1'b0;
              end
              cyc_ticks_d = cyc_ticks_q + 1'b1;
            end else begin
              cyc_ticks_d   = '0;
              cycles_done_d = cycles_done_q + 1'b1;
            end
          end
        end
        akvs_pkg::PH_DEFLATE: begin
          valve_d = '0;
          valve_d[akvs_pkg::V_REL] = 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q       <= akvs_pkg::PH_INFLATE;
      infl_ticks_q  <= '0;
      cyc_ticks_q   <= '0;
      cycles_done_q <= '0;
      valve_q       <= '0;
      out_vld_q     <= 1'b0;
    end else begin
      if (s_acc) begin
        phase_q       <= phase_d;
        infl_ticks_q  <= infl_ticks_d;
        cyc_ticks_q   <= cyc_ticks_d;
        cycles_done_q <= cycles_done_d;
        valve_q       <= valve_d;
        out_vld_q     <= 1'b1;
      end else if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      out_data_q <= {1'b0, phase_d, valve_d};
    end
  end

  // deflate is final
  a_deflate_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == akvs_pkg::PH_DEFLATE |=> phase_q == akvs_pkg::PH_DEFLATE)
    else $error("phase left deflate");

  // knead counters are clear outside the cyclic phase
  a_cyc_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q != akvs_pkg::PH_CYCLIC |-> (cycles_done_q == '0 && cyc_ticks_q == '0))
    else $error("knead counters not cleared");

  // a word that does not run leaves the sequence untouched
  a_frozen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_acc && !run) |=> ($stable(valve_q) && $stable(phase_q) && $stable(infl_ticks_q)))
    else $error("state moved on a frozen word");

  // result word matches the state it was taken from
  a_out_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_acc |=> (out_data_q[4:0] == valve_q && out_data_q[6:5] == phase_q))
    else $error("result word differs from state");

  // deflate with a running tick opens only the release valve
  a_deflate_valves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_acc && run && phase_q == akvs_pkg::PH_DEFLATE) |=>
      (valve_q == akvs_pkg::valve_t'(1 << akvs_pkg::V_REL)))
    else $error("deflate valve pattern wrong");

endmodule
